// ===== hw/rtl/aob_pkg.sv =====
// ============================================================================
// aob_pkg: shared types and constants of the additive oscillator bank
// Beat formats of both channels, command codes and fixed sine coefficients.
// ============================================================================
package aob_pkg;

    localparam int PHASE_W  = 32;
    localparam int SAMPLE_W = 24;
    localparam int SINE_LAT = 8;

    localparam int OUT_MAX = 8388607;
    localparam int OUT_MIN = -8388608;

    // Q30 coefficients of the odd sine polynomial.
    localparam logic [30:0] C1 = 31'd1686629713;
    localparam logic [30:0] C3 = 31'd693598670;
    localparam logic [30:0] C5 = 31'd85569306;
    localparam logic [30:0] C7 = 31'd5026995;
    localparam logic [30:0] C9 = 31'd172271;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_WR_TONE = 2'd1,
        CMD_WR_LFO  = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0]         command;
        logic [5:0]         osc_index;
        logic [PHASE_W-1:0] increment_value;
    } t_in_beat;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
    } t_out_beat;

endpackage

// ===== hw/rtl/aob_ram.sv =====
// ============================================================================
// aob_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ============================================================================
module aob_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 40,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/aob_sine.sv =====
// ============================================================================
// aob_sine: pipelined fixed-point sine of a phase word
// Quadrant folding and a Horner polynomial, at most one multiply per stage,
// give the signed Q1.23 result in a registered output.
// ============================================================================
module aob_sine #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                                i_clk,
    input  logic [aob_pkg::PHASE_W-1:0]         i_phase,
    output logic signed [aob_pkg::SAMPLE_W-1:0] o_sine
);

    localparam int QB = SINE_TABLE_BITS - 2;
    localparam logic [QB:0] QLEN = {1'b1, {QB{1'b0}}};

    function automatic logic [30:0] mul_q30(input logic [30:0] a, input logic [30:0] b);
        logic [61:0] p;
        p = a * b;
        return p[60:30];
    endfunction

    logic [SINE_TABLE_BITS-1:0] top_bits;
    logic [1:0]                 quad;
    logic [QB-1:0]              rem;
    logic [QB:0]                pos;
    logic [30:0]                x_in;
    logic [24:0]                rounded;
    logic [aob_pkg::SAMPLE_W-1:0] mag_sat;

    logic [30:0] r_x    [6];
    logic [30:0] r_x2   [1:4];
    logic [30:0] r_s    [2:5];
    logic [1:0]  r_quad [7];
    logic [30:0] r_mag;
    logic signed [aob_pkg::SAMPLE_W-1:0] r_sine;

    assign top_bits = i_phase[aob_pkg::PHASE_W-1 -: SINE_TABLE_BITS];
    assign quad     = top_bits[SINE_TABLE_BITS-1 -: 2];
    assign rem      = top_bits[QB-1:0];
    assign pos      = quad[0] ? (QLEN - {1'b0, rem}) : {1'b0, rem};
    assign x_in     = {pos, {(32 - SINE_TABLE_BITS){1'b0}}};

    always_comb begin
        rounded = {1'b0, r_mag[30:7]} + {24'd0, r_mag[6]};
        if (rounded > 25'(aob_pkg::OUT_MAX)) begin
            mag_sat = aob_pkg::SAMPLE_W'(aob_pkg::OUT_MAX);
        end else begin
            mag_sat = rounded[aob_pkg::SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0]    <= x_in;
        r_quad[0] <= quad;
        for (int j = 1; j < 6; j++) begin
            r_x[j] <= r_x[j-1];
        end
        for (int j = 1; j < 7; j++) begin
            r_quad[j] <= r_quad[j-1];
        end
        r_x2[1] <= mul_q30(r_x[0], r_x[0]);
        for (int j = 2; j < 5; j++) begin
            r_x2[j] <= r_x2[j-1];
        end
        r_s[2] <= aob_pkg::C7 - mul_q30(r_x2[1], aob_pkg::C9);
        r_s[3] <= aob_pkg::C5 - mul_q30(r_x2[2], r_s[2]);
        r_s[4] <= aob_pkg::C3 - mul_q30(r_x2[3], r_s[3]);
        r_s[5] <= aob_pkg::C1 - mul_q30(r_x2[4], r_s[4]);
        r_mag  <= mul_q30(r_x[5], r_s[5]);
        r_sine <= r_quad[6][1] ? -$signed(mag_sat) : $signed(mag_sat);
    end

    assign o_sine = r_sine;

endmodule

// ===== hw/rtl/additive_oscillator_bank_lfo.sv =====
// ============================================================================
// additive_oscillator_bank_lfo: sine oscillator bank with amplitude LFOs
// Phases and increments live in two RAMs that are walked once per tick; two
// sine pipelines, a square, a product and two accumulators mix the bank into
// one stereo sample, which a reciprocal multiply scales by the bank size.
//
//   channel   direction   beat         handshake
//   in        input       t_in_beat    i_in_valid / o_in_stall
//   out       output      t_out_beat   o_out_valid / i_out_stall
//
// A tick holds the input while it starts, reads the RAMs once per oscillator,
// runs each read through sine, square, product and accumulation, then
// latches the sums, multiplies them by the reciprocal of the bank size and
// loads the output register. A write command passes a read state and a
// write-back state; an ignored command leaves the block idle.
// The synchronous reset clears the control state and the per-entry valid bits,
// so every phase and increment reads as zero until it is written.
// A result waits in the output register while the next beat is taken; a tick
// that finishes while that register is still stalled waits for it.
// ============================================================================
module additive_oscillator_bank_lfo #(
    parameter int NUM_OSC         = 40,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  aob_pkg::t_in_beat  i_in_beat,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output aob_pkg::t_out_beat o_out_beat,
    input  logic               i_out_stall
);

    localparam int IDX_W = (NUM_OSC > 1) ? $clog2(NUM_OSC) : 1;
    localparam int ACC_W = 48 + $clog2(NUM_OSC);
    localparam int AW    = ACC_W - 24;
    localparam int RS    = AW + 6;
    localparam int SW    = aob_pkg::SAMPLE_W;
    localparam logic signed [ACC_W-1:0] HALF_D = ACC_W'(longint'(NUM_OSC) << 23);
    localparam logic signed [AW:0] SAT_HI = (AW + 1)'(aob_pkg::OUT_MAX);
    localparam logic signed [AW:0] SAT_LO = (AW + 1)'(aob_pkg::OUT_MIN);
    localparam logic [30:0] RECIP =
        31'(((longint'(1) << RS) + longint'(NUM_OSC) - 1) / longint'(NUM_OSC));

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WR_RD,
        ST_WR_WB,
        ST_TICK,
        ST_DRAIN,
        ST_DIV,
        ST_DONE
    } t_state;

    t_state r_state;
    logic [IDX_W-1:0] r_k;
    logic             r_rd_vld;
    logic [IDX_W-1:0] r_rd_addr;
    logic [aob_pkg::SINE_LAT-1:0] r_vsh;
    logic             r_q_vld;
    logic             r_p_vld;
    logic             r_ph_init;
    logic             r_inc_vld [NUM_OSC];
    logic [IDX_W-1:0] r_wr_addr;
    logic             r_wr_lfo;
    logic [31:0]      r_wr_val;
    logic [AW-1:0]    r_dq  [2];
    logic             r_neg [2];
    logic             r_out_vld;
    aob_pkg::t_out_beat r_out_beat;

    logic [23:0]             r_lsq;
    logic signed [SW-1:0]    r_tq;
    logic signed [47:0]      r_prod;
    logic                    r_par;
    logic signed [ACC_W-1:0] r_acc [2];

    logic             in_acc;
    logic             tick_start;
    logic             wr_ok;
    logic             empty;
    logic             out_free;
    logic [IDX_W-1:0] inc_raddr;
    logic [63:0]      ph_rdata;
    logic [63:0]      inc_rdata;
    logic [63:0]      ph_wdata;
    logic [63:0]      inc_wdata;
    logic [63:0]      inc_old;
    logic [31:0]      ph_tone;
    logic [31:0]      ph_lfo;
    logic [31:0]      inc_tone;
    logic [31:0]      inc_lfo;
    logic signed [SW-1:0] tone_sine;
    logic signed [SW-1:0] lfo_sine;
    logic signed [47:0]   lfo_sq_full;
    logic signed [48:0]   prod_full;
    logic signed [ACC_W-1:0] fin_num [2];
    logic [AW-1:0]    fin_a [2];
    logic [AW-1:0]    fin_m [2];
    logic [AW+30:0]   qprod [2];
    logic [AW-1:0]    dq_nx [2];
    logic signed [AW:0] quo_s [2];
    logic [SW-1:0]    sat_q [2];

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = (r_state == ST_IDLE) && i_in_valid;
    assign tick_start = in_acc && (i_in_beat.command == aob_pkg::CMD_TICK);
    assign wr_ok      = {1'b0, i_in_beat.osc_index} < 7'(NUM_OSC);
    assign empty      = !r_rd_vld && (r_vsh == '0) && !r_q_vld && !r_p_vld;
    assign out_free   = !r_out_vld || !i_out_stall;

    assign inc_raddr = (r_state == ST_WR_RD) ? r_wr_addr : r_k;

    aob_ram #(.WIDTH(64), .DEPTH(NUM_OSC), .ADDR_W(IDX_W)) u_phase_ram (
        .i_clk   (i_clk),
        .i_we    (r_rd_vld),
        .i_waddr (r_rd_addr),
        .i_wdata (ph_wdata),
        .i_raddr (r_k),
        .o_rdata (ph_rdata)
    );

    aob_ram #(.WIDTH(64), .DEPTH(NUM_OSC), .ADDR_W(IDX_W)) u_inc_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == ST_WR_WB),
        .i_waddr (r_wr_addr),
        .i_wdata (inc_wdata),
        .i_raddr (inc_raddr),
        .o_rdata (inc_rdata)
    );

    assign ph_tone  = r_ph_init ? ph_rdata[31:0]  : 32'd0;
    assign ph_lfo   = r_ph_init ? ph_rdata[63:32] : 32'd0;
    assign inc_tone = r_inc_vld[r_rd_addr] ? inc_rdata[31:0]  : 32'd0;
    assign inc_lfo  = r_inc_vld[r_rd_addr] ? inc_rdata[63:32] : 32'd0;
    assign ph_wdata = {ph_lfo + inc_lfo, ph_tone + inc_tone};

    assign inc_old   = r_inc_vld[r_wr_addr] ? inc_rdata : 64'd0;
    assign inc_wdata = r_wr_lfo ? {r_wr_val, inc_old[31:0]} : {inc_old[63:32], r_wr_val};

    aob_sine #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_tone_sine (
        .i_clk   (i_clk),
        .i_phase (ph_tone),
        .o_sine  (tone_sine)
    );

    aob_sine #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_lfo_sine (
        .i_clk   (i_clk),
        .i_phase (ph_lfo),
        .o_sine  (lfo_sine)
    );

    assign lfo_sq_full = lfo_sine * lfo_sine;
    assign prod_full   = r_tq * $signed({1'b0, r_lsq});

    always_comb begin
        for (int ch = 0; ch < 2; ch++) begin
            fin_num[ch] = r_acc[ch] + HALF_D;
            fin_a[ch]   = fin_num[ch][ACC_W-1:24];
            fin_m[ch]   = fin_a[ch][AW-1] ? (~fin_a[ch] + AW'(NUM_OSC)) : fin_a[ch];
            qprod[ch]   = (AW + 31)'(r_dq[ch]) * (AW + 31)'(RECIP);
            dq_nx[ch]   = AW'(qprod[ch] >> RS);
            quo_s[ch]   = r_neg[ch] ? -$signed({1'b0, r_dq[ch]}) : $signed({1'b0, r_dq[ch]});
            if (quo_s[ch] > SAT_HI) begin
                sat_q[ch] = SW'(aob_pkg::OUT_MAX);
            end else if (quo_s[ch] < SAT_LO) begin
                sat_q[ch] = SW'(aob_pkg::OUT_MIN);
            end else begin
                sat_q[ch] = quo_s[ch][SW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_k       <= '0;
            r_rd_vld  <= 1'b0;
            r_vsh     <= '0;
            r_q_vld   <= 1'b0;
            r_p_vld   <= 1'b0;
            r_ph_init <= 1'b0;
            r_out_vld <= 1'b0;
            for (int i = 0; i < NUM_OSC; i++) begin
                r_inc_vld[i] <= 1'b0;
            end
        end else begin
            r_rd_vld <= (r_state == ST_TICK);
            r_vsh    <= {r_vsh[aob_pkg::SINE_LAT-2:0], r_rd_vld};
            r_q_vld  <= r_vsh[aob_pkg::SINE_LAT-1];
            r_p_vld  <= r_q_vld;
            if ((r_state == ST_DONE) && out_free) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        case (aob_pkg::t_cmd'(i_in_beat.command))
                            aob_pkg::CMD_TICK: begin
                                r_k     <= '0;
                                r_state <= ST_TICK;
                            end
                            aob_pkg::CMD_WR_TONE, aob_pkg::CMD_WR_LFO: begin
                                if (wr_ok) begin
                                    r_wr_addr <= i_in_beat.osc_index[IDX_W-1:0];
                                    r_wr_lfo  <= (i_in_beat.command == aob_pkg::CMD_WR_LFO);
                                    r_wr_val  <= i_in_beat.increment_value;
                                    r_state   <= ST_WR_RD;
                                end
                            end
                            default: begin
                                r_state <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_WR_RD: begin
                    r_state <= ST_WR_WB;
                end
                ST_WR_WB: begin
                    r_inc_vld[r_wr_addr] <= 1'b1;
                    r_state              <= ST_IDLE;
                end
                ST_TICK: begin
                    r_rd_addr <= r_k;
                    if (r_k == IDX_W'(NUM_OSC - 1)) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    if (empty) begin
                        for (int ch = 0; ch < 2; ch++) begin
                            r_dq[ch]  <= fin_m[ch];
                            r_neg[ch] <= fin_a[ch][AW-1];
                        end
                        r_ph_init <= 1'b1;
                        r_state   <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    for (int ch = 0; ch < 2; ch++) begin
                        r_dq[ch] <= dq_nx[ch];
                    end
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_beat.left_sample  <= sat_q[0];
                        r_out_beat.right_sample <= sat_q[1];
                        r_state                 <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_lsq  <= lfo_sq_full[46:23];
        r_tq   <= tone_sine;
        r_prod <= prod_full[47:0];
        if (tick_start) begin
            r_acc[0] <= '0;
            r_acc[1] <= '0;
            r_par    <= 1'b0;
        end else if (r_p_vld) begin
            r_acc[r_par] <= r_acc[r_par] + ACC_W'(r_prod);
            r_par        <= !r_par;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_beat  = r_out_beat;

endmodule

// ===== hw/rtl/aob_chk.sv =====
// ============================================================================
// aob_chk: port-level checker for the additive oscillator bank
// Watches both channels for handshake rules and command-level behavior.
// ============================================================================
module aob_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input aob_pkg::t_in_beat  i_in_beat,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input aob_pkg::t_out_beat o_out_beat,
    input logic               i_out_stall
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_beat))
        else $error("Output beat changed or dropped while stalled.");

    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_beat.command == aob_pkg::CMD_TICK)
        |=> o_in_stall)
        else $error("Input taken again in the cycle after a tick beat.");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("Result appeared without a tick at work.");

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_beat.command != aob_pkg::CMD_TICK)
        |=> !$rose(o_out_valid))
        else $error("A non-tick command produced a result.");

endmodule

bind additive_oscillator_bank_lfo aob_chk u_aob_chk (.*);

// ===== tb/additive_oscillator_bank_lfo_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// additive_oscillator_bank_lfo_tb: self-checking bench for the oscillator bank
// Drives tick, increment-write and unused-command beats through the input channel under four
// idling regimes. A scoreboard predicts every stereo sample from its own copy
// of the phases and increments and checks each output beat in order.
// ============================================================================
module additive_oscillator_bank_lfo_tb;

    localparam int NUM_OSC         = 40;
    localparam int SINE_TABLE_BITS = 10;
    localparam int CYCLE_LIMIT     = 800000;
    localparam int DRAIN_CYCLES    = 200;
    localparam int PHASE_ITEMS     = 290;

    class sample_scoreboard;
        bit [aob_pkg::PHASE_W-1:0] tone_ph  [NUM_OSC];
        bit [aob_pkg::PHASE_W-1:0] lfo_ph   [NUM_OSC];
        bit [aob_pkg::PHASE_W-1:0] tone_inc [NUM_OSC];
        bit [aob_pkg::PHASE_W-1:0] lfo_inc  [NUM_OSC];
        aob_pkg::t_out_beat        expected_samples[$];
        int               failures;
        int               ticks;
        int               writes;
        int               ignored;
        int               samples_checked;

        function new();
            for (int k = 0; k < NUM_OSC; k++) begin
                tone_ph[k]  = '0;
                lfo_ph[k]   = '0;
                tone_inc[k] = '0;
                lfo_inc[k]  = '0;
            end
            failures        = 0;
            ticks           = 0;
            writes          = 0;
            ignored         = 0;
            samples_checked = 0;
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction

        // Polynomial sine of the top table bits of a phase, in Q1.23.
        function longint sine_q23(bit [aob_pkg::PHASE_W-1:0] ph);
            bit [31:0] top;
            bit [31:0] quad;
            bit [31:0] qlen;
            bit [31:0] r;
            bit [63:0] pos;
            bit [63:0] x;
            bit [63:0] x2;
            bit [63:0] s;
            bit [63:0] mag;
            top  = ph >> (32 - SINE_TABLE_BITS);
            quad = (top >> (SINE_TABLE_BITS - 2)) & 32'd3;
            qlen = 32'd1 << (SINE_TABLE_BITS - 2);
            r    = top & (qlen - 32'd1);
            pos  = quad[0] ? 64'(qlen - r) : 64'(r);
            x    = pos << (30 - (SINE_TABLE_BITS - 2));
            x2   = (x * x) >> 30;
            s    = 64'(aob_pkg::C9);
            s    = 64'(aob_pkg::C7) - ((x2 * s) >> 30);
            s    = 64'(aob_pkg::C5) - ((x2 * s) >> 30);
            s    = 64'(aob_pkg::C3) - ((x2 * s) >> 30);
            s    = 64'(aob_pkg::C1) - ((x2 * s) >> 30);
            mag  = (x * s) >> 30;
            mag  = (mag + 64'd64) >> 7;
            if (mag > 64'(aob_pkg::OUT_MAX)) begin
                mag = 64'(aob_pkg::OUT_MAX);
            end
            return quad[1] ? -longint'(mag) : longint'(mag);
        endfunction

        // Divides a Q46 channel sum by twice the bank size, rounds it to Q1.23 and saturates it.
        function longint scale_channel(longint sum);
            longint d;
            longint num;
            longint q;
            d   = 2 * NUM_OSC * (longint'(1) << 23);
            num = sum + d / 2;
            if (num >= 0) begin
                q = num / d;
            end else begin
                q = -((-num + d - 1) / d);
            end
            if (q > aob_pkg::OUT_MAX) begin
                q = aob_pkg::OUT_MAX;
            end
            if (q < aob_pkg::OUT_MIN) begin
                q = aob_pkg::OUT_MIN;
            end
            return q;
        endfunction

        function void note_beat(aob_pkg::t_in_beat b);
            longint    acc[2];
            longint    l;
            longint    lsq;
            longint    t;
            aob_pkg::t_out_beat sample;
            case (b.command)
                aob_pkg::CMD_WR_TONE, aob_pkg::CMD_WR_LFO: begin
                    if (b.osc_index < NUM_OSC) begin
                        if (b.command == aob_pkg::CMD_WR_TONE) begin
                            tone_inc[b.osc_index] = b.increment_value;
                        end else begin
                            lfo_inc[b.osc_index] = b.increment_value;
                        end
                        writes++;
                    end else begin
                        ignored++;
                    end
                end
                aob_pkg::CMD_TICK: begin
                    acc[0] = 0;
                    acc[1] = 0;
                    for (int k = 0; k < NUM_OSC; k++) begin
                        l   = sine_q23(lfo_ph[k]);
                        lsq = (l * l) >>> 23;
                        t   = sine_q23(tone_ph[k]);
                        acc[k & 1] += t * lsq;
                        lfo_ph[k]  += lfo_inc[k];
                        tone_ph[k] += tone_inc[k];
                    end
                    sample.left_sample  = aob_pkg::SAMPLE_W'(scale_channel(acc[0]));
                    sample.right_sample = aob_pkg::SAMPLE_W'(scale_channel(acc[1]));
                    expected_samples.push_back(sample);
                    ticks++;
                end
                default: begin
                    ignored++;
                end
            endcase
        endfunction

        function void check_sample(aob_pkg::t_out_beat got);
            aob_pkg::t_out_beat want;
            if (expected_samples.size() == 0) begin
                $error("Output beat with no pending tick: left %0d right %0d",
                       got.left_sample, got.right_sample);
                failures++;
            end else begin
                want = expected_samples.pop_front();
                samples_checked++;
                if (got.left_sample !== want.left_sample) begin
                    $error("left_sample expected %0d actual %0d",
                           want.left_sample, got.left_sample);
                    failures++;
                end
                if (got.right_sample !== want.right_sample) begin
                    $error("right_sample expected %0d actual %0d",
                           want.right_sample, got.right_sample);
                    failures++;
                end
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    aob_pkg::t_in_beat  i_in_beat   = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    aob_pkg::t_out_beat o_out_beat;
    logic               i_out_stall = 1'b0;

    sample_scoreboard sb;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycle_count    = 0;

    additive_oscillator_bank_lfo #(
        .NUM_OSC         (NUM_OSC),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_beat   (i_in_beat),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat),
        .i_out_stall (i_out_stall)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_sample(o_out_beat);
        end
    end

    function automatic aob_pkg::t_in_beat make_beat(aob_pkg::t_cmd cmd, int idx,
                                                    bit [aob_pkg::PHASE_W-1:0] val);
        aob_pkg::t_in_beat b;
        b.command         = cmd;
        b.osc_index       = idx[5:0];
        b.increment_value = val;
        return b;
    endfunction

    function automatic bit [aob_pkg::PHASE_W-1:0] random_increment();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50) begin
            return $urandom;
        end else if (pick < 70) begin
            return $urandom_range(32'h0100_0000, 0);
        end else begin
            case ($urandom_range(5))
                0:       return 32'h0000_0000;
                1:       return 32'hFFFF_FFFF;
                2:       return 32'h4000_0000;
                3:       return 32'h8000_0000;
                4:       return 32'hC000_0000;
                default: return 32'h1 << $urandom_range(31);
            endcase
        end
    endfunction

    function automatic aob_pkg::t_in_beat random_beat();
        int pick;
        pick = $urandom_range(99);
        if (pick < 40) begin
            return make_beat(aob_pkg::CMD_TICK, $urandom_range(63), $urandom);
        end else if (pick < 85) begin
            return make_beat(($urandom_range(1) != 0) ? aob_pkg::CMD_WR_TONE
                                                      : aob_pkg::CMD_WR_LFO,
                             $urandom_range(NUM_OSC - 1), random_increment());
        end else if (pick < 93) begin
            return make_beat(($urandom_range(1) != 0) ? aob_pkg::CMD_WR_TONE
                                                      : aob_pkg::CMD_WR_LFO,
                             $urandom_range(63, NUM_OSC), $urandom);
        end else begin
            return make_beat(aob_pkg::CMD_NONE, $urandom_range(63), $urandom);
        end
    endfunction

    task automatic send_beat(aob_pkg::t_in_beat b);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= b;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_beat(b);
    endtask

    task automatic wait_for_samples();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) begin
            send_beat(random_beat());
        end
        wait_for_samples();
    endtask

    initial begin
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A tick straight after reset must see every phase and increment at zero.
        send_beat(make_beat(aob_pkg::CMD_TICK, 0, 32'h0));
        send_beat(make_beat(aob_pkg::CMD_WR_TONE, 0, 32'h4000_0000));
        send_beat(make_beat(aob_pkg::CMD_WR_LFO, 0, 32'h4000_0000));
        send_beat(make_beat(aob_pkg::CMD_TICK, 0, 32'h0));
        send_beat(make_beat(aob_pkg::CMD_TICK, 0, 32'h0));
        send_beat(make_beat(aob_pkg::CMD_WR_TONE, NUM_OSC - 1, 32'hFFFF_FFFF));
        send_beat(make_beat(aob_pkg::CMD_WR_LFO, NUM_OSC - 1, 32'h8000_0000));
        send_beat(make_beat(aob_pkg::CMD_WR_TONE, 1, 32'hC000_0000));
        send_beat(make_beat(aob_pkg::CMD_WR_LFO, 1, 32'h4000_0000));
        // Writes beyond the bank and the unused command must leave no trace.
        send_beat(make_beat(aob_pkg::CMD_WR_TONE, NUM_OSC, 32'h1234_5678));
        send_beat(make_beat(aob_pkg::CMD_WR_LFO, 63, 32'hFFFF_FFFF));
        send_beat(make_beat(aob_pkg::CMD_NONE, 63, 32'hFFFF_FFFF));
        send_beat(make_beat(aob_pkg::CMD_TICK, 63, 32'hFFFF_FFFF));
        send_beat(make_beat(aob_pkg::CMD_TICK, 0, 32'h0));
        send_beat(make_beat(aob_pkg::CMD_WR_TONE, 2, 32'h0000_0001));
        send_beat(make_beat(aob_pkg::CMD_WR_LFO, 2, 32'h0000_0000));
        send_beat(make_beat(aob_pkg::CMD_TICK, 0, 32'h0));
        send_beat(make_beat(aob_pkg::CMD_TICK, 0, 32'h0));
        send_beat(make_beat(aob_pkg::CMD_WR_TONE, 0, 32'h8000_0000));
        send_beat(make_beat(aob_pkg::CMD_TICK, 0, 32'h0));
        send_beat(make_beat(aob_pkg::CMD_TICK, 0, 32'h0));

        run_phase(0, 0, PHASE_ITEMS);
        run_phase(50, 0, PHASE_ITEMS);
        run_phase(0, 50, PHASE_ITEMS);
        run_phase(22, 22, PHASE_ITEMS);

        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d ticks with %0d samples checked, %0d increment writes",
                 sb.ticks, sb.samples_checked, sb.writes);
        $display("and %0d ignored beats under four idling regimes.", sb.ignored);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== additive_oscillator_bank_lfo.f =====
hw/rtl/aob_pkg.sv
hw/rtl/aob_ram.sv
hw/rtl/aob_sine.sv
hw/rtl/additive_oscillator_bank_lfo.sv
hw/rtl/aob_chk.sv
tb/additive_oscillator_bank_lfo_tb.sv
